>>> design/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int MAX_BURST_DEF = 256;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_BUS_FREE    = 2'd1;
    localparam logic [1:0] REG_STOP_RESTART = 2'd2;

    // Request codes on the input channel.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAIT1, PH_SA, PH_SB, PH_SC, PH_WAIT2, PH_RA0, PH_RA1, PH_RB, PH_RC,
        PH_ADDR_LO, PH_ADDR_HI, PH_REG_LO, PH_REG_HI, PH_DATA_LO, PH_DATA_HI,
        PH_RADDR_LO, PH_RADDR_HI, PH_RX_LO, PH_RX_HI,
        PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_MSTOP_A, PH_MSTOP_B, PH_MSTOP_C
    } phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [8:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic [15:0] half_period;
        logic [15:0] bus_free_time;
        logic        stop_before_restart;
    } cfg_t;

    typedef struct packed {
        logic       scl_level;
        logic       scl_enable;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       byte_taken;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       done_res;
        logic       nack_seen;
    } result_t;

endpackage

>>> design/i2cm_front.sv
`timescale 1ns / 1ps

module i2cm_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_req_type,
    input  logic [6:0]     s_dev_addr,
    input  logic [7:0]     s_reg_addr,
    input  logic [8:0]     s_byte_count,
    input  logic [7:0]     s_write_data,
    input  logic           s_sda_in,
    output logic           head_valid,
    output i2cm_pkg::item_t head_item,
    input  logic           head_pop
);
    import i2cm_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    item_t       classified;
    logic        push;

    // Classify the request code; code three counts as a plain tick.
    always_comb begin
        classified = '0;
        case (s_req_type)
            REQ_WRITE: classified.cmd = CMD_WRITE;
            REQ_READ:  classified.cmd = CMD_READ;
            default:   classified.cmd = CMD_TICK;
        endcase
        classified.dev_addr   = s_dev_addr;
        classified.reg_addr   = s_reg_addr;
        classified.byte_count = s_byte_count;
        classified.write_data = s_write_data;
        classified.sda_in     = s_sda_in;
    end

    assign s_ready    = (count_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

    // Two-entry queue towards the sequencer.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (head_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, head_pop};
        end
    end

endmodule

>>> design/i2cm_back.sv
`timescale 1ns / 1ps

module i2cm_back #(
    parameter int MAX_BURST = i2cm_pkg::MAX_BURST_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  i2cm_pkg::cfg_t    cfg,
    input  logic              head_valid,
    input  i2cm_pkg::item_t   head_item,
    output logic              head_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output i2cm_pkg::result_t m_result
);
    import i2cm_pkg::*;

    localparam int CW   = $clog2(MAX_BURST + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;

    phase_t      phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [CW-1:0] left_reg, left_next;
    logic [6:0]  dev_reg, dev_next;
    logic [7:0]  regad_reg, regad_next;
    logic        rmode_reg, rmode_next;
    logic        nack_reg, nack_next;
    logic [15:0] since_reg, since_next;

    result_t     res, res_reg;
    logic        valid_reg;
    logic [15:0] hp;
    logic        po;
    logic [15:0] timer_adv;
    logic [CMPW-1:0] n_ext;
    logic [CW-1:0]   n_sat;
    logic        stop_end;
    logic        tx_bit;
    logic        is_cmd;
    logic        left_le1;
    logic        pin_scl_en, pin_scl_lv, pin_sda_en, pin_sda_lv;

    assign head_pop = head_valid && (!valid_reg || m_ready);

    // Phase timer step shared by all timed phases.
    assign hp        = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
    assign po        = ({1'b0, timer_reg} + 17'd1) >= {1'b0, hp};
    assign timer_adv = po ? 16'd0 : timer_reg + 16'd1;
    assign tx_bit    = shift_reg[3'd7 - bit_reg[2:0]];
    assign left_le1  = (left_reg <= CW'(1));
    assign is_cmd    = (head_item.cmd == CMD_WRITE) || (head_item.cmd == CMD_READ);

    // Count saturated to the burst limit; a read of zero bytes reads one.
    always_comb begin
        n_ext = CMPW'(head_item.byte_count);
        if (n_ext > CMPW'(MAX_BURST)) begin
            n_ext = CMPW'(MAX_BURST);
        end
        if (head_item.cmd == CMD_READ && n_ext == '0) begin
            n_ext = CMPW'(1);
        end
        n_sat = n_ext[CW-1:0];
    end

    // Next state of the sequencer and the event flags of this item.
    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        dev_next   = dev_reg;
        regad_next = regad_reg;
        rmode_next = rmode_reg;
        nack_next  = nack_reg;
        stop_end   = 1'b0;
        res.scl_level  = pin_scl_lv;
        res.scl_enable = pin_scl_en;
        res.sda_level  = pin_sda_lv;
        res.sda_enable = pin_sda_en;
        res.busy_res   = (phase_reg != PH_IDLE);
        res.byte_taken = 1'b0;
        res.read_valid = 1'b0;
        res.read_data  = 8'd0;
        res.read_last  = 1'b0;
        res.done_res   = 1'b0;
        res.nack_seen  = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (is_cmd) begin
                    rmode_next = (head_item.cmd == CMD_READ);
                    left_next  = n_sat;
                    dev_next   = head_item.dev_addr;
                    regad_next = head_item.reg_addr;
                    nack_next  = 1'b0;
                    timer_next = 16'd0;
                    bit_next   = 4'd0;
                    phase_next = PH_WAIT1;
                    res.busy_res = 1'b1;
                end
            end
            PH_WAIT1, PH_WAIT2: begin
                if (since_reg >= cfg.bus_free_time) begin
                    phase_next = (phase_reg == PH_WAIT1) ? PH_SA : PH_RA1;
                    timer_next = 16'd0;
                end
            end
            PH_SA, PH_SB, PH_RA0, PH_RA1, PH_RB, PH_ADDR_LO, PH_REG_LO, PH_DATA_LO,
            PH_RADDR_LO, PH_RX_LO, PH_STOP_A, PH_STOP_B, PH_MSTOP_A, PH_MSTOP_B: begin
                timer_next = timer_adv;
                if (po) begin
                    case (phase_reg)
                        PH_SA:    phase_next = PH_SB;
                        PH_SB:    phase_next = PH_SC;
                        PH_RA0, PH_RA1: phase_next = PH_RB;
                        PH_RB:    phase_next = PH_RC;
                        PH_ADDR_LO:  phase_next = PH_ADDR_HI;
                        PH_REG_LO:   phase_next = PH_REG_HI;
                        PH_DATA_LO:  phase_next = PH_DATA_HI;
                        PH_RADDR_LO: phase_next = PH_RADDR_HI;
                        PH_RX_LO:    phase_next = PH_RX_HI;
                        PH_STOP_A:   phase_next = PH_STOP_B;
                        PH_STOP_B:   phase_next = PH_STOP_C;
                        PH_MSTOP_A:  phase_next = PH_MSTOP_B;
                        default:     phase_next = PH_MSTOP_C;
                    endcase
                end
            end
            PH_SC: begin
                timer_next = timer_adv;
                if (po) begin
                    phase_next = PH_ADDR_LO;
                    shift_next = {dev_reg, 1'b0};
                    bit_next   = 4'd0;
                end
            end
            PH_RC: begin
                timer_next = timer_adv;
                if (po) begin
                    phase_next = PH_RADDR_LO;
                    shift_next = {dev_reg, 1'b1};
                    bit_next   = 4'd0;
                end
            end
            PH_ADDR_HI, PH_REG_HI, PH_DATA_HI, PH_RADDR_HI: begin
                timer_next = timer_adv;
                if (po) begin
                    if (bit_reg < 4'd8) begin
                        bit_next = bit_reg + 4'd1;
                        case (phase_reg)
                            PH_ADDR_HI: phase_next = PH_ADDR_LO;
                            PH_REG_HI:  phase_next = PH_REG_LO;
                            PH_DATA_HI: phase_next = PH_DATA_LO;
                            default:    phase_next = PH_RADDR_LO;
                        endcase
                    end else begin
                        nack_next = nack_reg | head_item.sda_in;
                        if (phase_reg == PH_ADDR_HI) begin
                            phase_next = PH_REG_LO;
                            shift_next = regad_reg;
                            bit_next   = 4'd0;
                        end else if (phase_reg == PH_RADDR_HI) begin
                            phase_next = PH_RX_LO;
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                        end else if (rmode_reg) begin
                            phase_next = cfg.stop_before_restart ? PH_MSTOP_A : PH_RA0;
                        end else if (left_reg != '0) begin
                            phase_next = PH_DATA_LO;
                            shift_next = head_item.write_data;
                            bit_next   = 4'd0;
                            res.byte_taken = 1'b1;
                            left_next  = left_reg - CW'(1);
                        end else begin
                            phase_next = PH_STOP_A;
                        end
                    end
                end
            end
            PH_RX_HI: begin
                timer_next = timer_adv;
                if (po) begin
                    if (bit_reg < 4'd8) begin
                        shift_next = shift_reg;
                        shift_next[3'd7 - bit_reg[2:0]] =
                            shift_reg[3'd7 - bit_reg[2:0]] | head_item.sda_in;
                        if (bit_reg == 4'd7) begin
                            res.read_valid = 1'b1;
                            res.read_data  = shift_next;
                            res.read_last  = left_le1;
                        end
                        bit_next   = bit_reg + 4'd1;
                        phase_next = PH_RX_LO;
                    end else begin
                        if (left_reg > CW'(1)) begin
                            left_next  = left_reg - CW'(1);
                            phase_next = PH_RX_LO;
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                        end else begin
                            left_next  = '0;
                            phase_next = PH_STOP_A;
                        end
                    end
                end
            end
            PH_STOP_C: begin
                timer_next = timer_adv;
                if (po) begin
                    phase_next    = PH_IDLE;
                    stop_end      = 1'b1;
                    res.done_res  = 1'b1;
                    res.nack_seen = nack_reg;
                end
            end
            PH_MSTOP_C: begin
                timer_next = timer_adv;
                if (po) begin
                    phase_next = PH_WAIT2;
                    stop_end   = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                timer_next = 16'd0;
            end
        endcase
        if (stop_end) begin
            since_next = 16'd0;
        end else if (since_reg != 16'hFFFF) begin
            since_next = since_reg + 16'd1;
        end else begin
            since_next = since_reg;
        end
    end

    // Pin drives of the current phase.
    always_comb begin
        pin_scl_en = 1'b0;
        pin_scl_lv = 1'b1;
        pin_sda_en = 1'b0;
        pin_sda_lv = 1'b1;
        case (phase_reg)
            PH_SA, PH_SB, PH_RA1, PH_RB, PH_STOP_C, PH_MSTOP_C: begin
                pin_scl_en = 1'b1;
                pin_sda_en = 1'b1;
            end
            PH_SC, PH_RC, PH_STOP_B, PH_MSTOP_B: begin
                pin_scl_en = 1'b1;
                pin_sda_en = 1'b1;
                pin_sda_lv = 1'b0;
            end
            PH_RA0: begin
                pin_scl_en = 1'b1;
                pin_scl_lv = 1'b0;
                pin_sda_en = 1'b1;
            end
            PH_STOP_A, PH_MSTOP_A: begin
                pin_scl_en = 1'b1;
                pin_scl_lv = 1'b0;
                pin_sda_en = 1'b1;
                pin_sda_lv = 1'b0;
            end
            PH_ADDR_LO, PH_REG_LO, PH_DATA_LO, PH_RADDR_LO,
            PH_ADDR_HI, PH_REG_HI, PH_DATA_HI, PH_RADDR_HI: begin
                pin_scl_en = 1'b1;
                pin_scl_lv = (phase_reg == PH_ADDR_HI) || (phase_reg == PH_REG_HI) ||
                             (phase_reg == PH_DATA_HI) || (phase_reg == PH_RADDR_HI);
                if (bit_reg < 4'd8) begin
                    pin_sda_en = 1'b1;
                    pin_sda_lv = tx_bit;
                end
            end
            PH_RX_LO, PH_RX_HI: begin
                pin_scl_en = 1'b1;
                pin_scl_lv = (phase_reg == PH_RX_HI);
                if (bit_reg >= 4'd8) begin
                    pin_sda_en = 1'b1;
                    pin_sda_lv = left_le1;
                end
            end
            default: begin
                pin_scl_en = 1'b0;
            end
        endcase
    end

    // Sequencer state advances once per item taken from the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            timer_reg <= 16'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            left_reg  <= '0;
            dev_reg   <= 7'd0;
            regad_reg <= 8'd0;
            rmode_reg <= 1'b0;
            nack_reg  <= 1'b0;
            since_reg <= 16'd0;
        end else if (head_pop) begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            dev_reg   <= dev_next;
            regad_reg <= regad_next;
            rmode_reg <= rmode_next;
            nack_reg  <= nack_next;
            since_reg <= since_next;
        end
    end

    // Output register towards the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (head_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_pop) begin
            res_reg <= res;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = res_reg;

endmodule

>>> design/i2c_master_register_access_core.sv
`timescale 1ns / 1ps

// I2C master for register reads and writes, driven by one timing tick per item.
// The input channel (s_*) carries one tick each: a request code, the command
// operands, the next write byte and the sampled SDA level. The result channel
// (m_*) returns exactly one item per tick with the pin drives, read data and
// status flags for that tick.
// Items enter a two-entry queue and the sequencer consumes one per cycle while
// the result channel is not stalled, so the block then sustains one item per
// clock. A result is registered when its item leaves the queue and is held in an output register until taken.
// When the receiver stalls the output register holds, the queue fills, and
// s_ready drops after two further items; nothing is lost.
// The APB port writes half_period (0x0), bus_free_time (0x4) and
// stop_before_restart (0x8); pready is always high.
// Synchronous active-low reset empties the queue, returns the sequencer to idle
// and restores the register defaults of 5, 5 and 0.
module i2c_master_register_access_core #(
    parameter int MAX_BURST = i2cm_pkg::MAX_BURST_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [6:0]  s_dev_addr,
    input  logic [7:0]  s_reg_addr,
    input  logic [8:0]  s_byte_count,
    input  logic [7:0]  s_write_data,
    input  logic        s_sda_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_scl_enable,
    output logic        m_sda_level,
    output logic        m_sda_enable,
    output logic        m_busy_res,
    output logic        m_byte_taken,
    output logic        m_read_valid,
    output logic [7:0]  m_read_data,
    output logic        m_read_last,
    output logic        m_done_res,
    output logic        m_nack_seen
);
    import i2cm_pkg::*;

    cfg_t    cfg_reg;
    logic    head_valid, head_pop;
    item_t   head_item;
    result_t result;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period         <= 16'd5;
            cfg_reg.bus_free_time       <= 16'd5;
            cfg_reg.stop_before_restart <= 1'b0;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_HALF_PERIOD:  cfg_reg.half_period         <= pwdata[15:0];
                REG_BUS_FREE:     cfg_reg.bus_free_time       <= pwdata[15:0];
                REG_STOP_RESTART: cfg_reg.stop_before_restart <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HALF_PERIOD:  prdata = {16'd0, cfg_reg.half_period};
            REG_BUS_FREE:     prdata = {16'd0, cfg_reg.bus_free_time};
            REG_STOP_RESTART: prdata = {31'd0, cfg_reg.stop_before_restart};
            default:          prdata = 32'd0;
        endcase
    end

    i2cm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_dev_addr  (s_dev_addr),
        .s_reg_addr  (s_reg_addr),
        .s_byte_count(s_byte_count),
        .s_write_data(s_write_data),
        .s_sda_in    (s_sda_in),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .head_pop    (head_pop)
    );

    i2cm_back #(
        .MAX_BURST(MAX_BURST)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .head_valid(head_valid),
        .head_item (head_item),
        .head_pop  (head_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    assign m_scl_level  = result.scl_level;
    assign m_scl_enable = result.scl_enable;
    assign m_sda_level  = result.sda_level;
    assign m_sda_enable = result.sda_enable;
    assign m_busy_res   = result.busy_res;
    assign m_byte_taken = result.byte_taken;
    assign m_read_valid = result.read_valid;
    assign m_read_data  = result.read_data;
    assign m_read_last  = result.read_last;
    assign m_done_res   = result.done_res;
    assign m_nack_seen  = result.nack_seen;

`ifndef ASSERT_OFF
    // Completion and data events only occur inside a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_done_res || m_byte_taken || m_read_valid) |-> m_busy_res)
        else $error("event flag outside a transaction");

    // A NACK report only comes with the final stop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nack_seen |-> m_done_res)
        else $error("nack reported without done");

    // Read data is zero unless a byte is reported.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_read_valid |-> (m_read_data == 8'd0) && !m_read_last)
        else $error("read data without read_valid");

    // A done tick releases nothing mid-stop: SCL and SDA are both driven high.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_scl_enable && m_sda_enable && m_sda_level)
        else $error("done outside the final stop step");
`endif

endmodule
